// File: rtl/core/magnetic_vector_decoder_macros.svh
// Assertion macros used by the top-level decoder source.
`ifndef MAGNETIC_VECTOR_DECODER_MACROS_SVH
`define MAGNETIC_VECTOR_DECODER_MACROS_SVH

// Assert that a condition implies a consequence in the same cycle.
`define MVD_ASSERT_IMPL(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define MVD_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/mvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mvd_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int FRACTION_BITS = 8;
    localparam int GUARD_BITS = 8;
    localparam int INV_GAIN_Q16 = 39797;
    localparam int FS = 16 - FRACTION_BITS;
    // CORDIC datapath width: covers the grown xy length and guard bits.
    localparam int CW = 34;
    localparam int AW = 34;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [1:0] REG_FIELD_GAIN = 2'd0;
    localparam logic [1:0] REG_TEMP_OFFSET = 2'd1;
    localparam logic [1:0] REG_TEMP_GAIN = 2'd2;
    localparam logic [1:0] REG_TEMP_REF = 2'd3;

    // Scaled values handed from the front part to the CORDIC back part.
    typedef struct packed {
        logic signed [19:0] fx;
        logic signed [19:0] fy;
        logic signed [19:0] fz;
        logic signed [21:0] temp;
    } front_item_t;

    // atan(2^-i) with 2^31 = pi.
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] r;
        case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/mvd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mvd_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic [47:0] in_data,
    input  wire logic [15:0] field_gain,
    input  wire logic [11:0] temp_zero_code,
    input  wire logic [15:0] temp_gain,
    input  wire logic [7:0]  temp_reference,
    output logic      out_valid,
    input  wire logic out_ready,
    output mvd_pkg::front_item_t out_item
);
    import mvd_pkg::*;

    logic signed [11:0] cx, cy, cz;
    logic [11:0] tcode;
    logic signed [12:0] tdiff;
    logic signed [28:0] px, py, pz;
    logic signed [29:0] pt;
    logic signed [28:0] rx, ry, rz;
    logic signed [29:0] rt;
    logic signed [30:0] tsum;
    logic s1_valid_reg;
    logic signed [28:0] px_reg, py_reg, pz_reg;
    logic signed [29:0] pt_reg;
    logic signed [7:0] ref_reg;
    logic s2_valid_reg;
    front_item_t item_reg;
    logic s1_adv, s2_adv;

    function automatic logic signed [19:0] sat20(input logic signed [28:0] v);
        if (v > 29'sd524287) return 20'sd524287;
        if (v < -29'sd524288) return -20'sd524288;
        return v[19:0];
    endfunction

    function automatic logic signed [21:0] sat22(input logic signed [30:0] v);
        if (v > 31'sd2097151) return 22'sd2097151;
        if (v < -31'sd2097152) return -22'sd2097152;
        return v[21:0];
    endfunction

    // Unpack the readout bytes into counts and the temperature code.
    assign cx = {in_data[7:0], in_data[39:36]};
    assign cy = {in_data[15:8], in_data[35:32]};
    assign cz = {in_data[23:16], in_data[43:40]};
    assign tcode = {in_data[31:24], 1'b0, in_data[47:46], 1'b0};
    assign tdiff = $signed({1'b0, tcode}) - $signed({1'b0, temp_zero_code});
    assign px = cx * $signed({1'b0, field_gain});
    assign py = cy * $signed({1'b0, field_gain});
    assign pz = cz * $signed({1'b0, field_gain});
    assign pt = tdiff * $signed({1'b0, temp_gain});

    assign s2_adv = !s2_valid_reg || out_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    // Stage one registers the products; stage two registers the rounded, saturated item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            px_reg <= px;
            py_reg <= py;
            pz_reg <= pz;
            pt_reg <= pt;
            ref_reg <= $signed(temp_reference);
        end
        if (s2_adv && s1_valid_reg)
        begin
            item_reg.fx <= sat20(rx);
            item_reg.fy <= sat20(ry);
            item_reg.fz <= sat20(rz);
            item_reg.temp <= sat22(tsum);
        end
    end

    // Round half up, then saturate.
    assign rx = (px_reg + (29'sd1 <<< (FS - 1))) >>> FS;
    assign ry = (py_reg + (29'sd1 <<< (FS - 1))) >>> FS;
    assign rz = (pz_reg + (29'sd1 <<< (FS - 1))) >>> FS;
    assign rt = (pt_reg + (30'sd1 <<< (FS - 1))) >>> FS;
    assign tsum = 31'(rt) + (31'(ref_reg) <<< FRACTION_BITS);

    assign out_valid = s2_valid_reg;
    assign out_item = item_reg;
endmodule
`default_nettype wire

// File: rtl/core/mvd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mvd_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire mvd_pkg::front_item_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output mvd_pkg::front_item_t out_item
);
    import mvd_pkg::*;

    front_item_t mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0] cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != (QAW+1)'(QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_item = mem_reg[rp_reg];

    // Pointer and fill bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_item;
    end
endmodule
`default_nettype wire

// File: rtl/core/mvd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mvd_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire mvd_pkg::front_item_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [135:0] out_data
);
    import mvd_pkg::*;

    localparam int NS = 2 * CORDIC_STEPS + 6;

    // One pipeline stage per slot; the whole pipe stalls together.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] a;
        logic signed [19:0] fx;
        logic signed [19:0] fy;
        logic signed [19:0] fz;
        logic signed [21:0] temp;
        logic signed [15:0] az;
        logic zero;
    } stage_t;

    stage_t st_reg [NS];
    logic [NS-1:0] v_reg;
    logic adv;
    stage_t st_next [NS];

    assign adv = !v_reg[NS-1] || out_ready;
    assign in_ready = adv;

    // Combinational step of each stage.
    always_comb
    begin
        logic signed [CW-1:0] x0, y0;
        logic signed [63:0] prod;
        st_next[0] = '0;
        for (int k = 1; k < NS; k++)
        begin
            st_next[k] = st_reg[k-1];
        end
        // Stage 0: prerotate for pass one.
        x0 = CW'(in_item.fx) <<< GUARD_BITS;
        y0 = CW'(in_item.fy) <<< GUARD_BITS;
        st_next[0].fx = in_item.fx;
        st_next[0].fy = in_item.fy;
        st_next[0].fz = in_item.fz;
        st_next[0].temp = in_item.temp;
        st_next[0].zero = (x0 == '0) && (y0 == '0);
        st_next[0].x = x0;
        st_next[0].y = y0;
        st_next[0].a = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                st_next[0].x = y0;
                st_next[0].y = -x0;
                st_next[0].a = 34'sd1073741824;
            end
            else
            begin
                st_next[0].x = -y0;
                st_next[0].y = x0;
                st_next[0].a = -34'sd1073741824;
            end
        end
        // Pass one iterations.
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            stage_t p;
            p = st_reg[i];
            if (p.y >= 0)
            begin
                st_next[i+1].x = p.x + (p.y >>> i);
                st_next[i+1].y = p.y - (p.x >>> i);
                st_next[i+1].a = p.a + atan_tab(i);
            end
            else
            begin
                st_next[i+1].x = p.x - (p.y >>> i);
                st_next[i+1].y = p.y + (p.x >>> i);
                st_next[i+1].a = p.a - atan_tab(i);
            end
        end
        // Gain removal for the xy length, azimuth rounding.
        prod = 64'(st_reg[CORDIC_STEPS].x) * 64'(INV_GAIN_Q16);
        st_next[CORDIC_STEPS+1].x = CW'((prod + 64'sd32768) >>> 16);
        st_next[CORDIC_STEPS+1].az = 16'((st_reg[CORDIC_STEPS].a + 34'sd32768) >>> 16);
        if (st_reg[CORDIC_STEPS].zero)
        begin
            st_next[CORDIC_STEPS+1].x = '0;
            st_next[CORDIC_STEPS+1].az = '0;
        end
        // Load pass two.
        st_next[CORDIC_STEPS+2].y = CW'(st_reg[CORDIC_STEPS+1].fz) <<< GUARD_BITS;
        st_next[CORDIC_STEPS+2].a = '0;
        st_next[CORDIC_STEPS+2].zero = (st_reg[CORDIC_STEPS+1].x == '0)
            && (st_reg[CORDIC_STEPS+1].fz == '0);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            stage_t p;
            p = st_reg[CORDIC_STEPS+2+i];
            if (p.y >= 0)
            begin
                st_next[CORDIC_STEPS+3+i].x = p.x + (p.y >>> i);
                st_next[CORDIC_STEPS+3+i].y = p.y - (p.x >>> i);
                st_next[CORDIC_STEPS+3+i].a = p.a + atan_tab(i);
            end
            else
            begin
                st_next[CORDIC_STEPS+3+i].x = p.x - (p.y >>> i);
                st_next[CORDIC_STEPS+3+i].y = p.y + (p.x >>> i);
                st_next[CORDIC_STEPS+3+i].a = p.a - atan_tab(i);
            end
        end
        // Magnitude gain multiply with rounding, and elevation rounding.
        prod = 64'(st_reg[NS-3].x) * 64'(INV_GAIN_Q16);
        st_next[NS-2].x = CW'(((prod + (64'sd1 <<< (15 + GUARD_BITS)))
            >>> (16 + GUARD_BITS)));
        st_next[NS-2].a = (st_reg[NS-3].a + 34'sd32768) >>> 16;
        // Saturate elevation and magnitude.
        st_next[NS-1].x = (st_reg[NS-2].x > 34'sd1048575) ? 34'sd1048575
            : (st_reg[NS-2].x < 0 ? '0 : st_reg[NS-2].x);
        st_next[NS-1].a = (st_reg[NS-2].a > 34'sd16384) ? 34'sd16384
            : (st_reg[NS-2].a < -34'sd16384 ? -34'sd16384 : st_reg[NS-2].a);
        if (st_reg[NS-2].zero)
        begin
            st_next[NS-1].x = '0;
            st_next[NS-1].a = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NS; k++) st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_data = {2'b0, st_reg[NS-1].a[15:0], st_reg[NS-1].az,
        st_reg[NS-1].temp, st_reg[NS-1].x[19:0], st_reg[NS-1].fz,
        st_reg[NS-1].fy, st_reg[NS-1].fx};
endmodule
`default_nettype wire

// File: rtl/core/magnetic_vector_decoder.sv
// Path from an input transfer to an output transfer: 2 front stages, the queue memory
// register and 38 CORDIC pipeline stages.
// Throughput: one frame per cycle unless the output stalls; each CORDIC pass is unrolled into 16 stages.
// An output stall holds the whole CORDIC pipeline; the 4-entry queue absorbs the front.
// Reset: asynchronous, active low; control and configuration registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "magnetic_vector_decoder_macros.svh"
module magnetic_vector_decoder (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  wire logic s_tvalid,
    output logic s_tready,
    // x_high, y_high, z_high, temp_high, xy_low, z_temp_low
    input  wire logic [47:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // field_x, field_y, field_z, magnitude, temperature, azimuth, elevation
    output logic [135:0] m_tdata
);
    import mvd_pkg::*;

    logic [15:0] fgain_reg, tgain_reg;
    logic [11:0] toff_reg;
    logic [7:0] tref_reg;
    logic wr;
    logic fv, fr, qv, qr;
    front_item_t fi, qi;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fgain_reg <= 16'd8511;
            toff_reg <= 12'd1180;
            tgain_reg <= 16'd15729;
            tref_reg <= 8'd25;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_FIELD_GAIN: fgain_reg <= pwdata[15:0];
                REG_TEMP_OFFSET: toff_reg <= pwdata[11:0];
                REG_TEMP_GAIN: tgain_reg <= pwdata[15:0];
                REG_TEMP_REF: tref_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FIELD_GAIN: prdata = {16'b0, fgain_reg};
            REG_TEMP_OFFSET: prdata = {20'b0, toff_reg};
            REG_TEMP_GAIN: prdata = {16'b0, tgain_reg};
            REG_TEMP_REF: prdata = {24'b0, tref_reg};
            default: prdata = '0;
        endcase
    end

    mvd_front u_front (.clk, .rst_n, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata), .field_gain(fgain_reg), .temp_zero_code(toff_reg),
        .temp_gain(tgain_reg), .temp_reference(tref_reg),
        .out_valid(fv), .out_ready(fr), .out_item(fi));
    mvd_queue u_queue (.clk, .rst_n, .in_valid(fv), .in_ready(fr), .in_item(fi),
        .out_valid(qv), .out_ready(qr), .out_item(qi));
    mvd_back u_back (.clk, .rst_n, .in_valid(qv), .in_ready(qr), .in_item(qi),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata));

    `MVD_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[135:134] == 2'b00)
    `MVD_ASSERT_IMPL(a_el_range, m_tvalid, ($signed(m_tdata[133:118]) >= -16'sd16384) && ($signed(m_tdata[133:118]) <= 16'sd16384))
    `MVD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `MVD_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata))
endmodule
`default_nettype wire
